// File: rtl/tgm_pkg.sv
// Shared types, constants and command encoding for the touch gesture to mouse motion block.
`default_nettype none
package tgm_pkg;

    localparam int COORD_BITS    = 12;
    localparam int FINGER_BITS   = 3;
    localparam int TIME_BITS     = 32;
    localparam int THR_BITS      = 8;
    localparam int TIMEOUT_BITS  = 16;
    localparam int GAIN_BITS     = 16;
    localparam int GAIN_FRAC     = 16;
    localparam int PROD_BITS     = COORD_BITS + GAIN_BITS;
    localparam int MOVE_BITS     = 8;
    localparam int KIND_BITS     = 2;
    localparam int IN_BITS       = FINGER_BITS + 2 * COORD_BITS + TIME_BITS;
    localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = 2 * MOVE_BITS;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_DRAG_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_TAP_TIMEOUT    = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_GAIN           = 2'd2;

    localparam logic [THR_BITS-1:0]     RST_DRAG_THRESHOLD = 8'd5;
    localparam logic [TIMEOUT_BITS-1:0] RST_TAP_TIMEOUT    = 16'd250;
    localparam logic [GAIN_BITS-1:0]    RST_GAIN           = 16'd1311;

    localparam logic [KIND_BITS-1:0] KIND_MOTION  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_TAP     = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_RELEASE = 2'd2;

    localparam logic [MOVE_BITS-2:0] MOVE_MAX = 7'd127;

    typedef enum logic [1:0] {
        CMD_MOTION,
        CMD_TAP_REL,
        CMD_REL
    } t_cmd_kind;

    typedef struct packed {
        logic [FINGER_BITS-1:0] finger_count;
        logic [COORD_BITS-1:0]  pos_x;
        logic [COORD_BITS-1:0]  pos_y;
        logic [TIME_BITS-1:0]   now_ms;
    } t_touch;

    typedef struct packed {
        logic [THR_BITS-1:0]     drag_threshold;
        logic [TIMEOUT_BITS-1:0] tap_limit_ms;
        logic [GAIN_BITS-1:0]    gain_q16;
    } t_cfg;

    typedef struct packed {
        t_cmd_kind             kind;
        logic                  neg_x;
        logic [COORD_BITS-1:0] mag_x;
        logic                  neg_y;
        logic [COORD_BITS-1:0] mag_y;
    } t_cmd;

endpackage
`default_nettype wire

// File: rtl/tgm_front.sv
// Front end: accepts touch beats, tracks touch and drag state and issues report commands.
`default_nettype none
module tgm_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_vld,
    output logic                o_rdy,
    input  wire tgm_pkg::t_touch i_touch,
    input  wire tgm_pkg::t_cfg  i_cfg,
    input  wire logic           i_q_full,
    output logic                o_push,
    output tgm_pkg::t_cmd       o_cmd
);

    logic                            r_touching, n_touching;
    logic                            r_dragging, n_dragging;
    logic [tgm_pkg::COORD_BITS-1:0]  r_origin_x, n_origin_x;
    logic [tgm_pkg::COORD_BITS-1:0]  r_origin_y, n_origin_y;
    logic [tgm_pkg::COORD_BITS-1:0]  r_prev_x, n_prev_x;
    logic [tgm_pkg::COORD_BITS-1:0]  r_prev_y, n_prev_y;
    logic [tgm_pkg::TIME_BITS-1:0]   r_press_time, n_press_time;

    logic                            accept;
    logic                            released;
    logic [tgm_pkg::COORD_BITS-1:0]  dist_x, dist_y;
    logic                            drag_start;
    logic                            motion;
    logic [tgm_pkg::TIME_BITS-1:0]   held;
    logic                            is_tap;

    assign o_rdy  = !i_q_full;
    assign accept = i_vld && o_rdy;
    assign released = (i_touch.finger_count == '0);

    always_comb begin
        dist_x = (i_touch.pos_x >= r_origin_x) ? i_touch.pos_x - r_origin_x
                                                : r_origin_x - i_touch.pos_x;
        dist_y = (i_touch.pos_y >= r_origin_y) ? i_touch.pos_y - r_origin_y
                                                : r_origin_y - i_touch.pos_y;
        drag_start = !r_dragging &&
            ((dist_x > tgm_pkg::COORD_BITS'(i_cfg.drag_threshold)) ||
             (dist_y > tgm_pkg::COORD_BITS'(i_cfg.drag_threshold)));
        motion = r_dragging && (i_touch.finger_count == tgm_pkg::FINGER_BITS'(1)) &&
            ((i_touch.pos_x != r_prev_x) || (i_touch.pos_y != r_prev_y));
        held   = i_touch.now_ms - r_press_time;
        is_tap = !r_dragging && (held < tgm_pkg::TIME_BITS'(i_cfg.tap_limit_ms));
    end

    always_comb begin
        n_touching   = r_touching;
        n_dragging   = r_dragging;
        n_origin_x   = r_origin_x;
        n_origin_y   = r_origin_y;
        n_prev_x     = r_prev_x;
        n_prev_y     = r_prev_y;
        n_press_time = r_press_time;
        if (accept) begin
            if (!released) begin
                if (!r_touching) begin
                    n_touching   = 1'b1;
                    n_dragging   = 1'b0;
                    n_press_time = i_touch.now_ms;
                    n_origin_x   = i_touch.pos_x;
                    n_origin_y   = i_touch.pos_y;
                    n_prev_x     = i_touch.pos_x;
                    n_prev_y     = i_touch.pos_y;
                end else begin
                    if (drag_start) begin
                        n_dragging = 1'b1;
                    end
                    if (drag_start || motion) begin
                        n_prev_x = i_touch.pos_x;
                        n_prev_y = i_touch.pos_y;
                    end
                end
            end else if (r_touching) begin
                n_touching = 1'b0;
                n_dragging = 1'b0;
            end
        end
    end

    always_comb begin
        o_push       = 1'b0;
        o_cmd.kind   = tgm_pkg::CMD_REL;
        o_cmd.neg_x  = i_touch.pos_x < r_prev_x;
        o_cmd.neg_y  = i_touch.pos_y < r_prev_y;
        o_cmd.mag_x  = o_cmd.neg_x ? r_prev_x - i_touch.pos_x : i_touch.pos_x - r_prev_x;
        o_cmd.mag_y  = o_cmd.neg_y ? r_prev_y - i_touch.pos_y : i_touch.pos_y - r_prev_y;
        if (accept && r_touching) begin
            if (!released) begin
                o_push     = motion;
                o_cmd.kind = tgm_pkg::CMD_MOTION;
            end else begin
                o_push     = 1'b1;
                o_cmd.kind = is_tap ? tgm_pkg::CMD_TAP_REL : tgm_pkg::CMD_REL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touching   <= 1'b0;
            r_dragging   <= 1'b0;
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_press_time <= '0;
        end else begin
            r_touching   <= n_touching;
            r_dragging   <= n_dragging;
            r_origin_x   <= n_origin_x;
            r_origin_y   <= n_origin_y;
            r_prev_x     <= n_prev_x;
            r_prev_y     <= n_prev_y;
            r_press_time <= n_press_time;
        end
    end

endmodule
`default_nettype wire

// File: rtl/tgm_queue.sv
// Short command queue between the front end and the report generator.
`default_nettype none
module tgm_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tgm_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_vld,
    input  wire logic          i_pop,
    output tgm_pkg::t_cmd      o_cmd
);

    localparam int PTR_BITS = $clog2(tgm_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(tgm_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(tgm_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(tgm_pkg::QUEUE_DEPTH);

    tgm_pkg::t_cmd         r_mem [tgm_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic                  do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_vld   = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("command queue count beyond its depth");

    a_push_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("command pushed into a full queue");

endmodule
`default_nettype wire

// File: rtl/tgm_back.sv
// Report generator: scales motion by the gain and emits motion, tap and release beats.
`default_nettype none
module tgm_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_q_vld,
    input  wire tgm_pkg::t_cmd                  i_q_cmd,
    output logic                                o_q_pop,
    input  wire logic [tgm_pkg::GAIN_BITS-1:0]  i_gain_q16,
    output logic                                o_vld,
    input  wire logic                           i_rdy,
    output logic signed [tgm_pkg::MOVE_BITS-1:0] o_move_x,
    output logic signed [tgm_pkg::MOVE_BITS-1:0] o_move_y,
    output logic [tgm_pkg::KIND_BITS-1:0]       o_kind,
    output logic                                o_last
);

    function automatic logic [tgm_pkg::MOVE_BITS-1:0] scale_sat(
        input logic [tgm_pkg::PROD_BITS-1:0] prod,
        input logic                          neg
    );
        logic [tgm_pkg::COORD_BITS-1:0]  whole;
        logic [tgm_pkg::MOVE_BITS-2:0]   mag;
        whole = prod[tgm_pkg::PROD_BITS-1:tgm_pkg::GAIN_FRAC];
        mag   = (|whole[tgm_pkg::COORD_BITS-1:tgm_pkg::MOVE_BITS-1]) ? tgm_pkg::MOVE_MAX
                : whole[tgm_pkg::MOVE_BITS-2:0];
        return neg ? tgm_pkg::MOVE_BITS'(-{1'b0, mag}) : {1'b0, mag};
    endfunction

    logic                           r_s1_vld;
    tgm_pkg::t_cmd_kind             r_s1_kind;
    logic                           r_s1_phase;
    logic                           r_s1_neg_x, r_s1_neg_y;
    logic [tgm_pkg::PROD_BITS-1:0]  r_s1_prod_x, r_s1_prod_y;

    logic                           r_out_vld;
    logic [tgm_pkg::MOVE_BITS-1:0]  r_out_mx, r_out_my;
    logic [tgm_pkg::KIND_BITS-1:0]  r_out_kind;
    logic                           r_out_last;

    logic                           out_free;
    logic                           s1_adv;
    logic                           s1_done;
    logic [tgm_pkg::MOVE_BITS-1:0]  beat_mx, beat_my;
    logic [tgm_pkg::KIND_BITS-1:0]  beat_kind;
    logic                           beat_last;

    assign out_free = !r_out_vld || i_rdy;
    assign s1_adv   = r_s1_vld && out_free;
    assign s1_done  = s1_adv && ((r_s1_kind != tgm_pkg::CMD_TAP_REL) || r_s1_phase);
    assign o_q_pop  = i_q_vld && (!r_s1_vld || s1_done);

    always_comb begin
        beat_mx   = '0;
        beat_my   = '0;
        beat_kind = tgm_pkg::KIND_RELEASE;
        beat_last = 1'b1;
        unique case (r_s1_kind)
            tgm_pkg::CMD_MOTION: begin
                beat_mx   = scale_sat(r_s1_prod_x, r_s1_neg_x);
                beat_my   = scale_sat(r_s1_prod_y, r_s1_neg_y);
                beat_kind = tgm_pkg::KIND_MOTION;
            end
            tgm_pkg::CMD_TAP_REL: begin
                if (!r_s1_phase) begin
                    beat_kind = tgm_pkg::KIND_TAP;
                    beat_last = 1'b0;
                end
            end
            default: begin
                beat_kind = tgm_pkg::KIND_RELEASE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s1_phase <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_s1_vld   <= 1'b1;
                r_s1_phase <= 1'b0;
            end else if (s1_done) begin
                r_s1_vld   <= 1'b0;
            end else if (s1_adv) begin
                r_s1_phase <= 1'b1;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_rdy) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_kind   <= i_q_cmd.kind;
            r_s1_neg_x  <= i_q_cmd.neg_x;
            r_s1_neg_y  <= i_q_cmd.neg_y;
            r_s1_prod_x <= i_q_cmd.mag_x * i_gain_q16;
            r_s1_prod_y <= i_q_cmd.mag_y * i_gain_q16;
        end
        if (s1_adv) begin
            r_out_mx   <= beat_mx;
            r_out_my   <= beat_my;
            r_out_kind <= beat_kind;
            r_out_last <= beat_last;
        end
    end

    assign o_vld    = r_out_vld;
    assign o_move_x = r_out_mx;
    assign o_move_y = r_out_my;
    assign o_kind   = r_out_kind;
    assign o_last   = r_out_last;

    a_tap_then_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_rdy && r_out_kind == tgm_pkg::KIND_TAP)
        |=> (r_out_vld && r_out_kind == tgm_pkg::KIND_RELEASE && r_out_last))
        else $error("tap beat not followed by a release beat");

    a_tap_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_kind == tgm_pkg::KIND_TAP) |-> !r_out_last)
        else $error("tap beat marked as last");

    a_motion_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_mx != 8'h80 && r_out_my != 8'h80))
        else $error("motion outside the saturation range");

endmodule
`default_nettype wire

// File: rtl/touch_gesture_to_mouse_motion.sv
// Top level of the touch gesture to mouse motion converter.
//
// Touch reports enter on the s_axis channel, one beat per report. The beat is
// taken whenever the command queue has room, so a new report can be accepted
// every cycle. Each report gives zero, one or two result beats on m_axis:
// a motion beat while dragging with one finger, or on release an optional tap
// beat followed by a release beat; tlast marks the final beat of a report.
// The first result beat of a report passes through the queue, then the gain
// multiply register, then the saturation into the output register.
// The report generator emits one beat per cycle while m_axis_tready is high,
// so motion reports sustain one per cycle and a tap release gives two beats.
// Configuration registers are written through i_cfg_we, i_cfg_addr and i_cfg_wdata;
// the user must write them only while no report is in flight; the block does not enforce it.
// Synchronous reset clears touch and drag state, empties the queue and loads
// the register defaults. When m_axis_tready is low, the output beat holds, the
// generator and queue fill, and s_axis_tready drops once the queue is full.
`default_nettype none
module touch_gesture_to_mouse_motion (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // finger_count, pos_x, pos_y, now_ms
    input  wire logic [tgm_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // move_x, move_y
    output logic [tgm_pkg::OUT_TDATA_BITS-1:0]         m_axis_tdata,
    // report_kind
    output logic [tgm_pkg::KIND_BITS-1:0]              m_axis_tuser,
    output logic                                       m_axis_tlast,
    input  wire logic                                  i_cfg_we,
    input  wire logic [tgm_pkg::CFG_ADDR_BITS-1:0]     i_cfg_addr,
    input  wire logic [tgm_pkg::CFG_DATA_BITS-1:0]     i_cfg_wdata
);

    tgm_pkg::t_cfg    r_cfg;
    tgm_pkg::t_touch  touch;
    tgm_pkg::t_cmd    push_cmd, head_cmd;
    logic             push, q_full, q_vld, q_pop;
    logic signed [tgm_pkg::MOVE_BITS-1:0] move_x, move_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drag_threshold <= tgm_pkg::RST_DRAG_THRESHOLD;
            r_cfg.tap_limit_ms   <= tgm_pkg::RST_TAP_TIMEOUT;
            r_cfg.gain_q16       <= tgm_pkg::RST_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tgm_pkg::CFG_DRAG_THRESHOLD: begin
                    r_cfg.drag_threshold <= i_cfg_wdata[tgm_pkg::THR_BITS-1:0];
                end
                tgm_pkg::CFG_TAP_TIMEOUT: begin
                    r_cfg.tap_limit_ms <= i_cfg_wdata[tgm_pkg::TIMEOUT_BITS-1:0];
                end
                tgm_pkg::CFG_GAIN: begin
                    r_cfg.gain_q16 <= i_cfg_wdata[tgm_pkg::GAIN_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign touch.finger_count = s_axis_tdata[tgm_pkg::FINGER_BITS-1:0];
    assign touch.pos_x  = s_axis_tdata[tgm_pkg::FINGER_BITS +: tgm_pkg::COORD_BITS];
    assign touch.pos_y  = s_axis_tdata[tgm_pkg::FINGER_BITS + tgm_pkg::COORD_BITS
                                       +: tgm_pkg::COORD_BITS];
    assign touch.now_ms = s_axis_tdata[tgm_pkg::FINGER_BITS + 2 * tgm_pkg::COORD_BITS
                                       +: tgm_pkg::TIME_BITS];

    tgm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (s_axis_tvalid),
        .o_rdy    (s_axis_tready),
        .i_touch  (touch),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    tgm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd)
    );

    tgm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_vld    (q_vld),
        .i_q_cmd    (head_cmd),
        .o_q_pop    (q_pop),
        .i_gain_q16 (r_cfg.gain_q16),
        .o_vld      (m_axis_tvalid),
        .i_rdy      (m_axis_tready),
        .o_move_x   (move_x),
        .o_move_y   (move_y),
        .o_kind     (m_axis_tuser),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {move_y, move_x};

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the touch gesture to mouse motion converter.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 3000;
    localparam int PHASE_ITEMS = 250;
    localparam int NUM_PHASES  = 8;
    localparam int NUM_ROWS    = 25;

    typedef struct packed {
        logic [tgm_pkg::MOVE_BITS-1:0] dx;
        logic [tgm_pkg::MOVE_BITS-1:0] dy;
        logic [tgm_pkg::KIND_BITS-1:0] kind;
        logic                          last;
    } t_mouse_report;

    typedef enum logic [1:0] {
        OUT_PREDICTED,
        OUT_NONE,
        OUT_RELEASE,
        OUT_TAP_RELEASE
    } t_outcome;

    typedef struct packed {
        logic [tgm_pkg::FINGER_BITS-1:0] fingers;
        logic [tgm_pkg::COORD_BITS-1:0]  x;
        logic [tgm_pkg::COORD_BITS-1:0]  y;
        logic [tgm_pkg::TIME_BITS-1:0]   now;
        t_outcome                        how;
    } t_touch_row;

    localparam t_mouse_report TAP_REPORT = '{8'd0, 8'd0, tgm_pkg::KIND_TAP, 1'b0};
    localparam t_mouse_report REL_REPORT = '{8'd0, 8'd0, tgm_pkg::KIND_RELEASE, 1'b1};

    localparam t_touch_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{3'd0, 12'd0,    12'd0,    32'd0,          OUT_NONE},
        '{3'd1, 12'd100,  12'd100,  32'd1000,       OUT_NONE},
        '{3'd0, 12'd100,  12'd100,  32'd1100,       OUT_TAP_RELEASE},
        '{3'd1, 12'd0,    12'd0,    32'd2000,       OUT_NONE},
        '{3'd0, 12'd0,    12'd0,    32'd2250,       OUT_RELEASE},
        '{3'd1, 12'd0,    12'd0,    32'd3000,       OUT_NONE},
        '{3'd0, 12'd0,    12'd0,    32'd3249,       OUT_TAP_RELEASE},
        '{3'd3, 12'd4095, 12'd4095, 32'd4000,       OUT_NONE},
        '{3'd1, 12'd4090, 12'd4090, 32'd4001,       OUT_NONE},
        '{3'd1, 12'd4089, 12'd4095, 32'd4002,       OUT_NONE},
        '{3'd1, 12'd0,    12'd4095, 32'd4003,       OUT_PREDICTED},
        '{3'd1, 12'd4095, 12'd0,    32'd4004,       OUT_PREDICTED},
        '{3'd2, 12'd100,  12'd100,  32'd4005,       OUT_NONE},
        '{3'd7, 12'd200,  12'd200,  32'd4006,       OUT_NONE},
        '{3'd1, 12'd4095, 12'd4095, 32'd4007,       OUT_PREDICTED},
        '{3'd1, 12'd4095, 12'd4095, 32'd4008,       OUT_NONE},
        '{3'd1, 12'd4094, 12'd4095, 32'd4009,       OUT_PREDICTED},
        '{3'd0, 12'd4094, 12'd4095, 32'd10,         OUT_RELEASE},
        '{3'd5, 12'd50,   12'd60,   32'hFFFF_FFF0,  OUT_NONE},
        '{3'd0, 12'd50,   12'd60,   32'h0000_0010,  OUT_TAP_RELEASE},
        '{3'd6, 12'd10,   12'd10,   32'd500,        OUT_NONE},
        '{3'd6, 12'd10,   12'd16,   32'd501,        OUT_NONE},
        '{3'd1, 12'd30,   12'd5,    32'd502,        OUT_PREDICTED},
        '{3'd0, 12'd30,   12'd5,    32'd503,        OUT_RELEASE},
        '{3'd0, 12'd0,    12'd0,    32'd504,        OUT_NONE}
    };

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    // finger_count, pos_x, pos_y, now_ms
    logic [tgm_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    // move_x, move_y
    logic [tgm_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata;
    // report_kind
    logic [tgm_pkg::KIND_BITS-1:0]      m_axis_tuser;
    logic                               m_axis_tlast;
    logic                               i_cfg_we = 1'b0;
    logic [tgm_pkg::CFG_ADDR_BITS-1:0]  i_cfg_addr = '0;
    logic [tgm_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata = '0;

    logic [tgm_pkg::THR_BITS-1:0]     thr_r = tgm_pkg::RST_DRAG_THRESHOLD;
    logic [tgm_pkg::TIMEOUT_BITS-1:0] timeout_r = tgm_pkg::RST_TAP_TIMEOUT;
    logic [tgm_pkg::GAIN_BITS-1:0]    gain_r = tgm_pkg::RST_GAIN;

    logic                           touching = 1'b0;
    logic                           dragging = 1'b0;
    logic [tgm_pkg::COORD_BITS-1:0] org_x = '0;
    logic [tgm_pkg::COORD_BITS-1:0] org_y = '0;
    logic [tgm_pkg::COORD_BITS-1:0] last_x = '0;
    logic [tgm_pkg::COORD_BITS-1:0] last_y = '0;
    logic [tgm_pkg::TIME_BITS-1:0]  press_ms = '0;

    t_mouse_report expected_reports[$];
    int err_count = 0;
    int items_sent = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    touch_gesture_to_mouse_motion dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [tgm_pkg::COORD_BITS-1:0] abs_gap(
        input logic [tgm_pkg::COORD_BITS-1:0] a,
        input logic [tgm_pkg::COORD_BITS-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic logic [tgm_pkg::MOVE_BITS-1:0] scale_axis(
        input logic [tgm_pkg::COORD_BITS-1:0] cur,
        input logic [tgm_pkg::COORD_BITS-1:0] old);
        logic [tgm_pkg::PROD_BITS-1:0]  prod;
        logic [tgm_pkg::COORD_BITS-1:0] mag;
        prod = tgm_pkg::PROD_BITS'(abs_gap(cur, old)) * tgm_pkg::PROD_BITS'(gain_r);
        mag = prod[tgm_pkg::PROD_BITS-1:tgm_pkg::GAIN_FRAC];
        if (mag > tgm_pkg::COORD_BITS'(127))
            mag = tgm_pkg::COORD_BITS'(127);
        return (cur < old) ? -mag[tgm_pkg::MOVE_BITS-1:0] : mag[tgm_pkg::MOVE_BITS-1:0];
    endfunction

    function automatic int touch_step(input logic [tgm_pkg::FINGER_BITS-1:0] f,
                                      input logic [tgm_pkg::COORD_BITS-1:0] x,
                                      input logic [tgm_pkg::COORD_BITS-1:0] y,
                                      input logic [tgm_pkg::TIME_BITS-1:0] now,
                                      output t_mouse_report first,
                                      output t_mouse_report second);
        logic [tgm_pkg::TIME_BITS-1:0] held;
        first = '0;
        second = '0;
        if (f != 0) begin
            if (!touching) begin
                touching = 1'b1;
                dragging = 1'b0;
                press_ms = now;
                org_x = x;
                org_y = y;
                last_x = x;
                last_y = y;
                return 0;
            end
            if (!dragging && (abs_gap(x, org_x) > tgm_pkg::COORD_BITS'(thr_r) ||
                              abs_gap(y, org_y) > tgm_pkg::COORD_BITS'(thr_r))) begin
                dragging = 1'b1;
                last_x = x;
                last_y = y;
            end
            if (dragging && f == 1 && (x != last_x || y != last_y)) begin
                first = '{scale_axis(x, last_x), scale_axis(y, last_y),
                          tgm_pkg::KIND_MOTION, 1'b1};
                last_x = x;
                last_y = y;
                return 1;
            end
            return 0;
        end
        if (!touching)
            return 0;
        touching = 1'b0;
        held = now - press_ms;
        if (!dragging && held < tgm_pkg::TIME_BITS'(timeout_r)) begin
            first = TAP_REPORT;
            second = REL_REPORT;
            return 2;
        end
        dragging = 1'b0;
        first = REL_REPORT;
        return 1;
    endfunction

    function automatic logic [tgm_pkg::COORD_BITS-1:0] step_coord(
        input logic [tgm_pkg::COORD_BITS-1:0] c,
        input int reach);
        int lo;
        int hi;
        lo = int'(c) - reach;
        hi = int'(c) + reach;
        if (lo < 0)
            lo = 0;
        if (hi > 4095)
            hi = 4095;
        return tgm_pkg::COORD_BITS'($urandom_range(hi, lo));
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        err_count++;
        $display("mismatch in %s: got %h, expected %h at %0t", field, got, want, $realtime);
    endtask

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_touch(input logic [tgm_pkg::FINGER_BITS-1:0] f,
                              input logic [tgm_pkg::COORD_BITS-1:0] x,
                              input logic [tgm_pkg::COORD_BITS-1:0] y,
                              input logic [tgm_pkg::TIME_BITS-1:0] now,
                              input t_outcome how);
        t_mouse_report r0;
        t_mouse_report r1;
        int n;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= tgm_pkg::IN_TDATA_BITS'({now, y, x, f});
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        n = touch_step(f, x, y, now, r0, r1);
        case (how)
            OUT_PREDICTED: begin
                if (n > 0)
                    expected_reports.push_back(r0);
                if (n > 1)
                    expected_reports.push_back(r1);
            end
            OUT_RELEASE: begin
                expected_reports.push_back(REL_REPORT);
            end
            OUT_TAP_RELEASE: begin
                expected_reports.push_back(TAP_REPORT);
                expected_reports.push_back(REL_REPORT);
            end
            default: begin
            end
        endcase
        items_sent++;
        @(negedge i_clk);
    endtask

    // A touch-down, zero to ten moves with mixed finger counts, then a release.
    task automatic send_gesture();
        logic [tgm_pkg::FINGER_BITS-1:0] f;
        logic [tgm_pkg::COORD_BITS-1:0]  x;
        logic [tgm_pkg::COORD_BITS-1:0]  y;
        logic [tgm_pkg::TIME_BITS-1:0]   t0;
        logic [tgm_pkg::TIME_BITS-1:0]   t_rel;
        int reach;
        x = tgm_pkg::COORD_BITS'($urandom);
        y = tgm_pkg::COORD_BITS'($urandom);
        t0 = $urandom;
        f = ($urandom_range(3) == 0) ? tgm_pkg::FINGER_BITS'($urandom_range(7, 2)) : 3'd1;
        send_touch(f, x, y, t0, OUT_PREDICTED);
        repeat ($urandom_range(10, 0)) begin
            case ($urandom_range(4))
                0: reach = 1;
                1: reach = int'(thr_r) + 2;
                2: reach = 40;
                3: reach = 400;
                default: reach = 4095;
            endcase
            x = step_coord(x, reach);
            y = step_coord(y, reach);
            f = ($urandom_range(4) == 0) ? tgm_pkg::FINGER_BITS'($urandom_range(7, 2))
                                         : 3'd1;
            send_touch(f, x, y, $urandom, OUT_PREDICTED);
        end
        case ($urandom_range(3))
            0: t_rel = t0 + $urandom_range(300, 0);
            1: t_rel = t0 + timeout_r - 1 + $urandom_range(2, 0);
            2: t_rel = t0 + $urandom_range(70000, 0);
            default: t_rel = $urandom;
        endcase
        send_touch(3'd0, tgm_pkg::COORD_BITS'($urandom), tgm_pkg::COORD_BITS'($urandom),
                   t_rel, OUT_PREDICTED);
    endtask

    task automatic configure(input logic [tgm_pkg::THR_BITS-1:0] thr,
                             input logic [tgm_pkg::TIMEOUT_BITS-1:0] tmo,
                             input logic [tgm_pkg::GAIN_BITS-1:0] gain);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= tgm_pkg::CFG_DRAG_THRESHOLD;
        i_cfg_wdata <= tgm_pkg::CFG_DATA_BITS'(thr);
        @(negedge i_clk);
        i_cfg_addr <= tgm_pkg::CFG_TAP_TIMEOUT;
        i_cfg_wdata <= tmo;
        @(negedge i_clk);
        i_cfg_addr <= tgm_pkg::CFG_GAIN;
        i_cfg_wdata <= gain;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        thr_r = thr;
        timeout_r = tmo;
        gain_r = gain;
    endtask

    task automatic settle(input int tail);
        while (expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        t_mouse_report got;
        t_mouse_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tuser, m_axis_tlast};
            if (expected_reports.size() == 0) begin
                report_mismatch("unexpected beat", 8'(got.kind), 8'hFF);
            end else begin
                want = expected_reports.pop_front();
                if (got.dx !== want.dx)
                    report_mismatch("move_x", got.dx, want.dx);
                if (got.dy !== want.dy)
                    report_mismatch("move_y", got.dy, want.dy);
                if (got.kind !== want.kind)
                    report_mismatch("report_kind", 8'(got.kind), 8'(want.kind));
                if (got.last !== want.last)
                    report_mismatch("last_of_run", 8'(got.last), 8'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int goal;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED_ROWS[i])
            send_touch(DIRECTED_ROWS[i].fingers, DIRECTED_ROWS[i].x, DIRECTED_ROWS[i].y,
                       DIRECTED_ROWS[i].now, DIRECTED_ROWS[i].how);

        goal = 0;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                s_axis_tvalid <= 1'b0;
                settle(16);
                case (phase)
                    1: configure(8'd0, 16'd0, 16'hFFFF);
                    2: configure(8'd255, 16'hFFFF, 16'd0);
                    3: configure(8'd255, 16'd0, 16'hFFFF);
                    4: configure(8'd0, 16'hFFFF, 16'd1);
                    7: configure(tgm_pkg::RST_DRAG_THRESHOLD, tgm_pkg::RST_TAP_TIMEOUT,
                                 tgm_pkg::RST_GAIN);
                    default: configure(tgm_pkg::THR_BITS'($urandom_range(255, 0)),
                                       tgm_pkg::TIMEOUT_BITS'($urandom_range(600, 0)),
                                       tgm_pkg::GAIN_BITS'($urandom_range(65535, 0)));
                endcase
            end
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            goal += PHASE_ITEMS;
            while (items_sent < goal) begin
                if ($urandom_range(99) < 85)
                    send_gesture();
                else
                    send_touch(tgm_pkg::FINGER_BITS'($urandom_range(7, 0)),
                               tgm_pkg::COORD_BITS'($urandom),
                               tgm_pkg::COORD_BITS'($urandom), $urandom, OUT_PREDICTED);
            end
        end

        s_axis_tvalid <= 1'b0;
        settle(20);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
